@@ rtl/tcw_pkg.sv @@
// Types and constants shared by the text console writer modules.
// No dependencies.
package tcw_pkg;

   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_ERASE = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } tcw_req_type;

   typedef struct packed {
      logic [10:0] cursor_cell;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
      logic        scrolled;
   } tcw_rsp_type;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_ERASE,
      OP_CLEAR,
      OP_READ
   } tcw_op_type;

   typedef struct packed {
      tcw_op_type  op;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
      logic        index_ok;
   } tcw_cmd_type;

   typedef struct packed {
      logic pop;
      logic wiping;
   } tcw_back_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SCROLL_COPY,
      ST_SCROLL_ZERO,
      ST_FILL
   } tcw_state_type;

endpackage

@@ rtl/tcw_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; #(
   parameter int CELLS = 2000
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tcw_req_type         req_data,
   output logic                busy,
   input  tcw_back_status_type back_status,
   output logic                cmd_valid,
   output tcw_cmd_type         cmd
);

   tcw_cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   tcw_cmd_type             cmd_in;
   logic                    accept;

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH)) || back_status.wiping;
   assign accept    = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.char_code  = req_data.char_code;
      cmd_in.cell_index = req_data.cell_index;
      cmd_in.index_ok   = (32'(req_data.cell_index) < 32'(CELLS));
      case (req_data.action)
         ACT_PUT: begin
            cmd_in.op = (req_data.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
         end
         ACT_ERASE: cmd_in.op = OP_ERASE;
         ACT_CLEAR: cmd_in.op = OP_CLEAR;
         ACT_READ:  cmd_in.op = OP_READ;
         default:   cmd_in.op = OP_READ;
      endcase
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = back_status.pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({accept, back_status.pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

@@ rtl/tcw_back.sv @@
// Back end: screen buffer memory, cursor, scroll/clear sweeps and result register.
// Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          text_attribute,
   input  logic                cmd_valid,
   input  tcw_cmd_type         cmd,
   output tcw_back_status_type back_status,
   output logic                rsp_valid,
   output tcw_rsp_type         rsp_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(CELLS);
   localparam int COLW  = $clog2(COLUMNS);
   localparam logic [CW-1:0]   LAST_CELL   = CW'(CELLS - 1);
   localparam logic [CW-1:0]   SCROLL_BASE = CW'(CELLS - COLUMNS);
   localparam logic [CW-1:0]   COPY_LAST   = CW'(CELLS - COLUMNS - 1);
   localparam logic [CW-1:0]   COLS_C      = CW'(COLUMNS);
   localparam logic [COLW-1:0] COL_LAST    = COLW'(COLUMNS - 1);

   logic [15:0]     mem [CELLS];
   logic [15:0]     mem_rd_ff;
   logic            mem_we;
   logic [CW-1:0]   mem_wa;
   logic [CW-1:0]   mem_ra;
   logic [15:0]     mem_wd;

   tcw_state_type   state_ff, state_in;
   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [CW-1:0]   sweep_ff, sweep_in;
   logic [15:0]     fill_cell_ff, fill_cell_in;
   logic            wiping_ff, wiping_in;
   logic            read_ok_ff, read_ok_in;
   logic            rsp_valid_ff, rsp_valid_in;
   tcw_rsp_type     rsp_ff, rsp_in;
   logic            pop;
   logic [CW-1:0]   nl_cursor;
   logic [COLW-1:0] put_col;
   logic            scroll_put;
   logic            scroll_nl;

   assign nl_cursor  = cursor_ff - CW'(col_ff) + COLS_C;
   assign put_col    = (col_ff == COL_LAST) ? '0 : col_ff + COLW'(1);
   assign scroll_put = (cursor_ff == LAST_CELL);
   assign scroll_nl  = (cursor_ff >= SCROLL_BASE);

   assign back_status.pop    = pop;
   assign back_status.wiping = wiping_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_PUT:     state_in = scroll_put ? ST_SCROLL_COPY : ST_IDLE;
                  OP_NEWLINE: state_in = scroll_nl ? ST_SCROLL_COPY : ST_IDLE;
                  OP_CLEAR:   state_in = ST_FILL;
                  OP_READ:    state_in = ST_READ_WAIT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ_WAIT:   state_in = ST_IDLE;
         ST_SCROLL_COPY: if (sweep_ff == COPY_LAST) state_in = ST_SCROLL_ZERO;
         ST_SCROLL_ZERO: if (sweep_ff == LAST_CELL) state_in = ST_IDLE;
         ST_FILL:        if (sweep_ff == LAST_CELL) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      fill_cell_in = fill_cell_ff;
      wiping_in    = wiping_ff;
      read_ok_in   = read_ok_ff;
      mem_we       = 1'b0;
      mem_wa       = sweep_ff;
      mem_wd       = 16'd0;
      mem_ra       = '0;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               pop = 1'b1;
               case (cmd.op)
                  OP_PUT: begin
                     mem_we = 1'b1;
                     mem_wa = cursor_ff;
                     mem_wd = {text_attribute, cmd.char_code};
                     if (scroll_put) begin
                        cursor_in = SCROLL_BASE;
                        col_in    = '0;
                        sweep_in  = '0;
                        mem_ra    = COLS_C;
                     end else begin
                        cursor_in    = cursor_ff + CW'(1);
                        col_in       = put_col;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     if (scroll_nl) begin
                        cursor_in = SCROLL_BASE;
                        sweep_in  = '0;
                        mem_ra    = COLS_C;
                     end else begin
                        cursor_in    = nl_cursor;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     rsp_valid_in = 1'b1;
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - CW'(1);
                        col_in    = (col_ff == '0) ? COL_LAST : col_ff - COLW'(1);
                        mem_we    = 1'b1;
                        mem_wa    = cursor_ff - CW'(1);
                        mem_wd    = {text_attribute, SPACE_CODE};
                     end
                  end
                  OP_CLEAR: begin
                     cursor_in    = '0;
                     col_in       = '0;
                     sweep_in     = '0;
                     fill_cell_in = {text_attribute, SPACE_CODE};
                  end
                  OP_READ: begin
                     mem_ra     = cmd.index_ok ? CW'(cmd.cell_index) : '0;
                     read_ok_in = cmd.index_ok;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            if (read_ok_ff) begin
               rsp_in.read_char = mem_rd_ff[7:0];
               rsp_in.read_attr = mem_rd_ff[15:8];
            end
         end
         ST_SCROLL_COPY: begin
            // read runs one cell ahead of the write
            mem_we   = 1'b1;
            mem_wd   = mem_rd_ff;
            sweep_in = sweep_ff + CW'(1);
            if (sweep_ff != COPY_LAST) begin
               mem_ra = sweep_ff + COLS_C + CW'(1);
            end
         end
         ST_SCROLL_ZERO: begin
            mem_we = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               rsp_valid_in    = 1'b1;
               rsp_in.scrolled = 1'b1;
            end else begin
               sweep_in = sweep_ff + CW'(1);
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            mem_wd = fill_cell_ff;
            if (sweep_ff == LAST_CELL) begin
               wiping_in    = 1'b0;
               rsp_valid_in = !wiping_ff;
            end else begin
               sweep_in = sweep_ff + CW'(1);
            end
         end
         default: pop = 1'b0;
      endcase
      rsp_in.cursor_cell = 11'(cursor_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cursor_ff    <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         fill_cell_ff <= 16'd0;
         wiping_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         sweep_ff     <= sweep_in;
         fill_cell_ff <= fill_cell_in;
         wiping_ff    <= wiping_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_ok_ff <= read_ok_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

endmodule

@@ rtl/text_console_writer.sv @@
// Text console writer top level: attribute register, request queue front end and
// screen buffer back end. Depends on tcw_pkg, tcw_front and tcw_back.
//
// Usage:
//   Requests enter on start/req_data and are taken at an edge where start is
//   high and busy is low. A two-entry queue holds requests for the back end;
//   busy is high while it is full.
//   Each request gives one result, shown on rsp_data for one cycle with
//   rsp_valid high. Results come in request order; the receiver cannot stall.
//   Once the back end takes a request from the head of the queue, put, newline
//     and erase pass only the result register; a read passes the registered
//     memory read and then the result register. A clear, or a put or newline
//     that scrolls, sweeps the whole screen memory, one cell per cycle, before
//     its result; the back end takes no new request during the sweep.
//   csr_data sets the attribute byte; csr_ready is always high. Write it only
//   while no request is pending.
//   After reset the screen memory is zeroed with busy
//   held high; the cursor is at cell 0 and the attribute is 15.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  tcw_req_type req_data,
   output logic        busy,
   output logic        rsp_valid,
   output tcw_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int CELLS = COLUMNS * ROWS;

   logic [7:0]          attr_ff, attr_in;
   logic                cmd_valid;
   tcw_cmd_type         cmd;
   tcw_back_status_type back_status;

   assign csr_ready = 1'b1;
   assign attr_in   = (csr_valid && csr_ready) ? csr_data : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= 8'd15;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tcw_front #(
      .CELLS (CELLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .back_status (back_status),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (attr_ff),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .back_status    (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

   a_wipe_busy: assert property (@(posedge clock) $fell(reset) |-> busy)
      else $error("busy low right after reset");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.scrolled |-> rsp_data.cursor_cell == 11'(CELLS - COLUMNS))
      else $error("scroll left cursor off the last row start");

   a_scroll_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.scrolled |-> rsp_data.read_char == 8'd0 &&
      rsp_data.read_attr == 8'd0)
      else $error("scroll result carries read data");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> cmd_valid)
      else $error("queue popped while empty");

endmodule
